### sv/sbbf_pkg.sv
// shared constants, types and helpers for the split block bloom filter
`default_nettype none

package sbbf_pkg;

  // default store size: log2 of the number of 256-bit blocks
  localparam int LOG2_MAX_BLOCKS_DEF = 10;

  localparam int NUM_WORDS = 8;
  localparam int WORD_W    = 32;
  localparam int BLOCK_W   = NUM_WORDS * WORD_W;
  localparam int POS_W     = 5;
  localparam int BIT_SHIFT = 27;

  localparam int          LOG2_BLOCKS_W   = 4;
  localparam logic [3:0]  LOG2_BLOCKS_RST = 4'd10;

  localparam logic [63:0] KEY_MIX_LOW  = 64'h736f6d6570736575;
  localparam logic [63:0] KEY_MIX_HIGH = 64'h646f72616e646f6d;

  localparam logic [WORD_W-1:0] SALT [NUM_WORDS] = '{
    32'h47b6137b, 32'h44974d91, 32'h8824ad5b, 32'ha2b7289d,
    32'h705495c7, 32'h2df1424b, 32'h9efc4947, 32'h5c6bfb31
  };

  // depth of the queue between front and back, a power of two
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_INSERT_KEY     = 2'd0,
    OP_QUERY_KEY      = 2'd1,
    OP_INSERT_PREHASH = 2'd2,
    OP_QUERY_PREHASH  = 2'd3
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // block address width, at least one bit
  function automatic int addr_w(input int log2_max);
    return (log2_max > 0) ? log2_max : 1;
  endfunction

endpackage

`default_nettype wire

### sv/split_block_bloom_filter_unit.sv
// top level of the split block bloom filter
`default_nettype none

// Split block Bloom filter over 2**LOG2_MAX_BLOCKS blocks of 256 bits (eight
// 32-bit words). Each input word inserts or queries one element, given as a
// 16-byte key (hashed by a 64x64 multiply and fold) or as a ready 64-bit hash;
// the operation code travels in s_axis_tuser. Inserts give no output word,
// each query gives one output word whose bit 0 is set when all eight bits of
// the element are found in its block. After reset the store is zeroed by a
// clearing pass over all 2**LOG2_MAX_BLOCKS blocks (1024 at the default),
// during which s_axis_tready stays low; cfg writes are taken at any time but
// must only be made while the block is idle. The front hashes one word at a
// time: a key word goes through accept, four multiply/fold steps and push, a
// prehash word through accept, salt and push. The back takes one word at a
// time through the block read, the registered ram read and the write-back or
// compare. A two-entry queue lets the two run independently, so the front
// hashes the next word while the back works on the last; key words are paced
// by the front multiply steps, prehash words by the back read-modify-write.
module split_block_bloom_filter_unit import sbbf_pkg::*; #(
  parameter int LOG2_MAX_BLOCKS = LOG2_MAX_BLOCKS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // configuration: log2_blocks
  input  wire logic         cfg_we,
  input  wire logic [3:0]   cfg_wdata,
  // input words
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [127:0] s_axis_tdata,  // [63:0] key_low, [127:64] key_high
  input  wire logic [1:0]   s_axis_tuser,  // [1:0] operation
  // result words
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic      [7:0]   m_axis_tdata   // [0] present, [7:1] zero
);

  localparam int AW = addr_w(LOG2_MAX_BLOCKS);
  localparam int QW = 1 + AW + NUM_WORDS * POS_W;

  logic [LOG2_BLOCKS_W-1:0] log2_blocks;
  logic                     clearing;
  logic                     q_push;
  logic                     q_pop;
  logic [QW-1:0]            q_in;
  logic [QW-1:0]            q_out;
  q_status_t                q_status;
  logic                     present;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      log2_blocks <= LOG2_BLOCKS_RST;
    end else if (cfg_we) begin
      log2_blocks <= cfg_wdata;
    end
  end

  // hashing front, holds off input during the clearing pass
  sbbf_front #(
    .LOG2_MAX_BLOCKS (LOG2_MAX_BLOCKS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .hold        (clearing),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_op       (s_axis_tuser),
    .in_key_low  (s_axis_tdata[63:0]),
    .in_key_high (s_axis_tdata[127:64]),
    .log2_blocks (log2_blocks),
    .q_push      (q_push),
    .q_data      (q_in),
    .q_status    (q_status)
  );

  // decoupling queue: query flag, block index, eight bit positions
  sbbf_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .status    (q_status)
  );

  // memory back with output register
  sbbf_back #(
    .LOG2_MAX_BLOCKS (LOG2_MAX_BLOCKS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_status    (q_status),
    .q_pop       (q_pop),
    .q_data      (q_out),
    .clearing    (clearing),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_present (present)
  );

  assign m_axis_tdata = {7'b0, present};

  // no word taken while the store is being cleared
  assert property (@(posedge clk) disable iff (rst) clearing |-> !s_axis_tready)
    else $error("input accepted during clearing pass");

  // queue never written when full
  assert property (@(posedge clk) disable iff (rst) q_push |-> !q_status.full)
    else $error("push into full queue");

  // queue never read when empty
  assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_status.empty)
    else $error("pop from empty queue");

  // no result raised in the cycle right after the clearing pass
  assert property (@(posedge clk) disable iff (rst)
      $rose(m_axis_tvalid) |-> !$past(clearing))
    else $error("result raised straight out of clearing");

endmodule

`default_nettype wire

### sv/sbbf_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module sbbf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### sv/sbbf_queue.sv
// short fifo between the hashing front and the memory back
`default_nettype none

module sbbf_queue import sbbf_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data,
  output q_status_t             status
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slots [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign pop_data     = slots[rd_ptr];
  assign status.full  = (count == CW'(QUEUE_DEPTH));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

### sv/sbbf_front.sv
// front: takes words, hashes keys, forms block index and bit positions
`default_nettype none

module sbbf_front import sbbf_pkg::*; #(
  parameter int LOG2_MAX_BLOCKS = LOG2_MAX_BLOCKS_DEF,
  localparam int AW = addr_w(LOG2_MAX_BLOCKS),
  localparam int QW = 1 + AW + NUM_WORDS * POS_W
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     hold,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [1:0]               in_op,
  input  wire logic [63:0]              in_key_low,
  input  wire logic [63:0]              in_key_high,
  input  wire logic [LOG2_BLOCKS_W-1:0] log2_blocks,
  output logic                          q_push,
  output logic      [QW-1:0]            q_data,
  input  wire q_status_t                q_status
);

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_MID,
    F_FOLD,
    F_SALT,
    F_PUSH
  } fstate_t;

  fstate_t     state;
  logic        query;
  logic [63:0] x;
  logic [63:0] y;
  logic [63:0] p00, p01, p10, p11;
  logic [33:0] mid;
  logic [63:0] hi_part;
  logic [63:0] h;
  logic [QW-1:0] entry;

  logic [63:0] lo_fold;
  logic [63:0] hi_fold;
  logic [4:0]  lb_eff;
  logic [5:0]  blk_shift;
  logic [WORD_W-1:0] blk_full;
  logic [NUM_WORDS*POS_W-1:0] pos_all;

  assign in_ready = (state == F_IDLE) && !hold;
  assign q_push   = (state == F_PUSH) && !q_status.full;
  assign q_data   = entry;

  // final fold of the 128-bit product
  assign lo_fold = {mid[31:0], p00[31:0]};
  assign hi_fold = hi_part + {32'b0, p10[63:32]} + {62'b0, mid[33:32]};

  // block index from the upper hash word
  assign lb_eff = ({1'b0, log2_blocks} > 5'(LOG2_MAX_BLOCKS)) ?
                  5'(LOG2_MAX_BLOCKS) : {1'b0, log2_blocks};
  assign blk_shift = 6'd32 - {1'b0, lb_eff};
  assign blk_full  = h[63:32] >> blk_shift;

  always_comb begin
    logic [WORD_W-1:0] prod;
    pos_all = '0;
    for (int k = 0; k < NUM_WORDS; k++) begin
      prod = h[WORD_W-1:0] * SALT[k];
      pos_all[k*POS_W +: POS_W] = POS_W'(prod >> BIT_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid && in_ready) begin
            query <= in_op[0];
            x     <= in_key_low ^ KEY_MIX_LOW;
            y     <= in_key_high ^ KEY_MIX_HIGH;
            h     <= in_key_low;
            if ((in_op == OP_INSERT_KEY) || (in_op == OP_QUERY_KEY)) begin
              state <= F_MUL;
            end else begin
              state <= F_SALT;
            end
          end
        end
        F_MUL: begin
          p00   <= x[31:0]  * y[31:0];
          p01   <= x[31:0]  * y[63:32];
          p10   <= x[63:32] * y[31:0];
          p11   <= x[63:32] * y[63:32];
          state <= F_MID;
        end
        F_MID: begin
          mid     <= {2'b0, p00[63:32]} + {2'b0, p01[31:0]} + {2'b0, p10[31:0]};
          hi_part <= p11 + {32'b0, p01[63:32]};
          state   <= F_FOLD;
        end
        F_FOLD: begin
          h     <= lo_fold ^ hi_fold;
          state <= F_SALT;
        end
        F_SALT: begin
          entry <= {query, blk_full[AW-1:0], pos_all};
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_status.full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/sbbf_back.sv
// back: clears the store, then does block read-modify-write or probe
`default_nettype none

module sbbf_back import sbbf_pkg::*; #(
  parameter int LOG2_MAX_BLOCKS = LOG2_MAX_BLOCKS_DEF,
  localparam int AW    = addr_w(LOG2_MAX_BLOCKS),
  localparam int QW    = 1 + AW + NUM_WORDS * POS_W,
  localparam int DEPTH = 1 << LOG2_MAX_BLOCKS
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire q_status_t     q_status,
  output logic               q_pop,
  input  wire logic [QW-1:0] q_data,
  output logic               clearing,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic               out_present
);

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_WAIT,
    B_EXEC
  } bstate_t;

  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  bstate_t            state;
  logic [AW-1:0]      clr_addr;
  logic               cur_query;
  logic [AW-1:0]      cur_block;
  logic [BLOCK_W-1:0] cur_mask;

  logic [BLOCK_W-1:0] new_mask;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [BLOCK_W-1:0] ram_wdata;
  logic               ram_re;
  logic [BLOCK_W-1:0] ram_rdata;
  logic               out_free;

  // one bit per 32-bit word from the queued bit positions
  always_comb begin
    new_mask = '0;
    for (int k = 0; k < NUM_WORDS; k++) begin
      new_mask[k*WORD_W + int'(q_data[k*POS_W +: POS_W])] = 1'b1;
    end
  end

  assign clearing  = (state == B_CLEAR);
  assign q_pop     = (state == B_IDLE) && !q_status.empty;
  assign ram_re    = q_pop;
  assign ram_we    = clearing || ((state == B_EXEC) && !cur_query);
  assign ram_waddr = clearing ? clr_addr : cur_block;
  assign ram_wdata = clearing ? '0 : (ram_rdata | cur_mask);
  assign out_free  = !out_valid || out_ready;

  sbbf_ram #(
    .WIDTH (BLOCK_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (q_data[NUM_WORDS*POS_W +: AW]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      // drop the word once taken, unless a new answer takes its place
      if (out_valid && out_ready && !((state == B_EXEC) && cur_query)) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST_ADDR) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (q_pop) begin
            cur_query <= q_data[QW-1];
            cur_block <= q_data[NUM_WORDS*POS_W +: AW];
            cur_mask  <= new_mask;
            state     <= B_WAIT;
          end
        end
        B_WAIT: begin
          state <= B_EXEC;
        end
        B_EXEC: begin
          if (!cur_query) begin
            state <= B_IDLE;
          end else if (out_free) begin
            out_valid   <= 1'b1;
            out_present <= ((ram_rdata & cur_mask) == cur_mask);
            state       <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### tb/sbbf_checker.sv
// checker for the split block bloom filter: predicts query answers and compares result words
`timescale 1ns / 1ps

module sbbf_checker import sbbf_pkg::*; #(
  parameter int LOG2_MAX_BLOCKS = LOG2_MAX_BLOCKS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [3:0]   cfg_wdata,
  input  wire logic         s_axis_tvalid,
  input  wire logic         s_axis_tready,
  input  wire logic [127:0] s_axis_tdata,  // [63:0] key_low, [127:64] key_high
  input  wire logic [1:0]   s_axis_tuser,  // [1:0] operation
  input  wire logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  input  wire logic [7:0]   m_axis_tdata,  // [0] present, [7:1] zero
  output int                mismatches,
  output int                pending
);

  localparam int STORE_WORDS = NUM_WORDS << LOG2_MAX_BLOCKS;

  logic [WORD_W-1:0] filter_mem [STORE_WORDS];
  logic [3:0]        log2_setting;
  bit                present_due [$];

  // key hash: mix both halves, full 128-bit product, fold high into low
  function automatic logic [63:0] key_fold_hash(input logic [63:0] lo, input logic [63:0] hi);
    logic [127:0] prod;
    prod = {64'd0, lo ^ KEY_MIX_LOW} * {64'd0, hi ^ KEY_MIX_HIGH};
    return prod[63:0] ^ prod[127:64];
  endfunction

  // set or test the eight-bit mask of one element in its block
  task automatic probe_store(input op_t op, input logic [63:0] lo, input logic [63:0] hi,
                             output bit is_query, output bit hit);
    logic [63:0]       hash;
    logic [63:0]       blk;
    logic [WORD_W-1:0] scaled;
    logic [WORD_W-1:0] mask;
    int unsigned       lb;
    int unsigned       widx;
    is_query = (op == OP_QUERY_KEY) || (op == OP_QUERY_PREHASH);
    hash = (op == OP_INSERT_KEY || op == OP_QUERY_KEY) ? key_fold_hash(lo, hi) : lo;
    lb = (log2_setting > LOG2_MAX_BLOCKS) ? LOG2_MAX_BLOCKS : log2_setting;
    blk = {32'd0, hash[63:32]} >> (32 - lb);
    blk &= (64'd1 << LOG2_MAX_BLOCKS) - 64'd1;
    hit = 1'b1;
    for (int k = 0; k < NUM_WORDS; k++) begin
      scaled = hash[31:0] * SALT[k];
      mask = 32'd1 << scaled[31:BIT_SHIFT];
      widx = (blk * NUM_WORDS + k) & (STORE_WORDS - 1);
      if (!is_query) filter_mem[widx] |= mask;
      else if ((filter_mem[widx] & mask) != mask) hit = 1'b0;
    end
  endtask

  initial begin
    mismatches = 0;
    pending = 0;
  end

  always @(posedge clk) begin : watch
    bit is_query;
    bit hit;
    bit due;
    if (rst) begin
      foreach (filter_mem[i]) filter_mem[i] = '0;
      log2_setting = LOG2_BLOCKS_RST;
      present_due.delete();
    end else begin
      if (cfg_we) log2_setting = cfg_wdata;
      if (s_axis_tvalid && s_axis_tready) begin
        probe_store(op_t'(s_axis_tuser), s_axis_tdata[63:0], s_axis_tdata[127:64],
                    is_query, hit);
        if (is_query) present_due.push_back(hit);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (present_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result word, expected none, got present %0d",
                   $time, m_axis_tdata[0]);
        end else begin
          due = present_due.pop_front();
          if (m_axis_tdata[0] !== due) begin
            mismatches++;
            $display("%0t: present mismatch, expected %0d, got %0d",
                     $time, due, m_axis_tdata[0]);
          end
        end
      end
    end
    pending = present_due.size();
  end

endmodule

### tb/tb_split_block_bloom_filter_unit.sv
// testbench top for the split block bloom filter: stimulus, handshake pacing and verdict
`timescale 1ns / 1ps

module tb_split_block_bloom_filter_unit import sbbf_pkg::*;;

  // register settings walked through, one phase each; 15 is above the
  // store size and must act like the largest setting
  localparam int         PHASES = 7;
  localparam logic [3:0] PHASE_SETTING [PHASES] = '{4'd0, 4'd15, 4'd3, 4'd10, 4'd1, 4'd6, 4'd11};
  localparam int         WORDS_PER_PHASE = 205;
  // cycles to let an insert finish in the back end before touching the register
  localparam int         SETTLE_CYCLES = 40;
  localparam int         POOL_SIZE = 64;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [3:0]   cfg_wdata = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;   // [63:0] key_low, [127:64] key_high
  logic [1:0]   s_axis_tuser = '0;   // [1:0] operation
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [7:0]   m_axis_tdata;        // [0] present, [7:1] zero

  int mismatches;
  int pending;

  // inserted elements kept around so later queries hit them
  logic [63:0] pool_lo [POOL_SIZE];
  logic [63:0] pool_hi [POOL_SIZE];
  bit          pool_key [POOL_SIZE];
  int          pool_n = 0;

  // burst mode turns off the random gaps for a stretch of words
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;

  always #10 clk = ~clk;

  split_block_bloom_filter_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  sbbf_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mismatches    (mismatches),
    .pending       (pending)
  );

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // present one word, called at a falling edge, returns at the falling edge
  // after the word was taken; tvalid is left high for a back-to-back follow-up
  task automatic send_word(input op_t op, input logic [63:0] lo, input logic [63:0] hi);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {hi, lo};
    s_axis_tuser  <= op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // stop sending and wait until every query answer has come back
  task automatic drain_answers();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // change log2_blocks only with the block idle, inserts included
  task automatic set_block_count(input logic [3:0] value);
    drain_answers();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mostly insert-then-query traffic on remembered elements, plus misses
  // and sparse bit patterns
  task automatic random_element();
    int          pick;
    int          slot;
    bit          as_key;
    logic [63:0] lo;
    logic [63:0] hi;
    op_t         op;
    pick = $urandom_range(0, 99);
    if (pick < 40 || pool_n == 0) begin
      as_key = $urandom_range(0, 1);
      lo = rand64();
      hi = rand64();
      op = as_key ? OP_INSERT_KEY : OP_INSERT_PREHASH;
      if (pool_n < POOL_SIZE) begin
        slot = pool_n;
        pool_n++;
      end else begin
        slot = $urandom_range(0, POOL_SIZE - 1);
      end
      pool_lo[slot]  = lo;
      pool_hi[slot]  = hi;
      pool_key[slot] = as_key;
    end else if (pick < 75) begin
      // query an element inserted earlier; key_high is noise for prehash
      slot = $urandom_range(0, pool_n - 1);
      lo = pool_lo[slot];
      hi = pool_key[slot] ? pool_hi[slot] : rand64();
      op = pool_key[slot] ? OP_QUERY_KEY : OP_QUERY_PREHASH;
    end else if (pick < 95) begin
      lo = rand64();
      hi = rand64();
      op = $urandom_range(0, 1) ? OP_QUERY_KEY : OP_QUERY_PREHASH;
    end else begin
      lo = 64'd1 << $urandom_range(0, 63);
      hi = ~(64'd1 << $urandom_range(0, 63));
      op = op_t'($urandom_range(0, 3));
    end
    send_word(op, lo, hi);
  endtask

  // result side: random stall before each word, with stretches of none
  initial begin : result_sink
    int gap;
    int served;
    served = 0;
    @(negedge clk);
    forever begin
      if (served % 40 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      gap = rx_burst ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      @(negedge clk);
      served++;
    end
  end

  // stimulus and verdict
  initial begin : stimulus
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part at the reset setting of 1024 blocks; the clearing pass
    // after reset simply holds off the first word
    send_word(OP_QUERY_KEY, 64'd0, 64'd0);                       // empty store
    send_word(OP_INSERT_KEY, 64'd0, 64'd0);
    send_word(OP_QUERY_KEY, 64'd0, 64'd0);
    send_word(OP_INSERT_KEY, '1, '1);
    send_word(OP_QUERY_KEY, '1, '1);
    send_word(OP_QUERY_KEY, 64'd1, 64'd0);
    send_word(OP_QUERY_KEY, 64'd0, '1);
    // zero hash lands on block 0, bit 0 of every word
    send_word(OP_INSERT_PREHASH, 64'd0, 64'h0123_4567_89ab_cdef);
    send_word(OP_QUERY_PREHASH, 64'd0, '1);
    send_word(OP_QUERY_PREHASH, '1, 64'd0);
    send_word(OP_INSERT_PREHASH, '1, rand64());
    send_word(OP_QUERY_PREHASH, '1, rand64());
    // top hash bit picks the upper half of the blocks
    send_word(OP_INSERT_PREHASH, 64'h8000_0000_0000_0000, '1);
    send_word(OP_QUERY_PREHASH, 64'h8000_0000_0000_0000, 64'd0);
    send_word(OP_QUERY_PREHASH, 64'hffff_ffff_0000_0000, 64'd0);

    // random phases, one per register setting, single block and an
    // oversized setting among them
    for (int p = 0; p < PHASES; p++) begin
      set_block_count(PHASE_SETTING[p]);
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        if (i % 40 == 0) tx_burst = ($urandom_range(0, 3) == 0);
        // sender holds off mid-phase until the result side has caught up
        if (i == WORDS_PER_PHASE / 2) drain_answers();
        random_element();
      end
    end

    drain_answers();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin : watchdog
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
